// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int ByteWidth     = 8;
   localparam int YawWidth      = 16;
   localparam int CsrIndexWidth = 2;

   localparam logic [ByteWidth-1:0] SyncByte    = 8'h55;
   localparam logic [ByteWidth-1:0] ZeroByte    = 8'h00;
   localparam logic [ByteWidth-1:0] EndByte     = 8'hAA;
   localparam logic [ByteWidth-1:0] MinLength   = 8'd9;
   localparam logic [ByteWidth-1:0] FrameBytes  = 8'd8;

   localparam logic [ByteWidth-1:0] YawAddrReset     = 8'd0;
   localparam logic [ByteWidth-1:0] BatteryAddrReset = 8'd1;
   localparam logic [ByteWidth-1:0] StatusAddrReset  = 8'd2;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_YAW_ADDR     = 2'd0,
      CSR_BATTERY_ADDR = 2'd1,
      CSR_STATUS_ADDR  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_FRAME_OK     = 2'd0,
      EV_CHECKSUM_ERR = 2'd1,
      EV_TRAILER_ERR  = 2'd2,
      EV_BAD_LENGTH   = 2'd3
   } event_type;

   typedef struct packed {
      logic [ByteWidth-1:0] yaw_address;
      logic [ByteWidth-1:0] battery_address;
      logic [ByteWidth-1:0] status_address;
   } cfg_type;

   typedef struct packed {
      event_type            event_code;
      logic [ByteWidth-1:0] frame_type;
      logic [ByteWidth-1:0] frame_address;
      logic [ByteWidth-1:0] frame_length;
      logic [YawWidth-1:0]  yaw_value;
      logic [ByteWidth-1:0] battery_level;
      logic [ByteWidth-1:0] operational_state;
   } result_type;

endpackage

// ===== rtl/sfr_parser.sv =====
`timescale 1ns / 1ps

// Frame parser state and its one-byte step. A step consumes one byte and
// may produce one result word.
module sfr_parser import sfr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  logic [ByteWidth-1:0] step_byte,
   input  cfg_type              cfg,
   output logic                 result_valid,
   output result_type           result
);

   typedef enum logic [8:0] {
      PH_SYNC    = 9'b000000001,
      PH_ZERO    = 9'b000000010,
      PH_LENGTH  = 9'b000000100,
      PH_TYPE    = 9'b000001000,
      PH_ADDRESS = 9'b000010000,
      PH_DATA    = 9'b000100000,
      PH_CHECK   = 9'b001000000,
      PH_TRAIL0  = 9'b010000000,
      PH_TRAIL1  = 9'b100000000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] type_ff, type_in;
   logic [ByteWidth-1:0] address_ff, address_in;
   logic [ByteWidth-1:0] index_ff, index_in;
   logic [ByteWidth-1:0] sum_ff, sum_in;
   logic [ByteWidth-1:0] first_ff, first_in;
   logic [ByteWidth-1:0] second_ff, second_in;
   logic [YawWidth-1:0]  yaw_ff, yaw_in;
   logic [ByteWidth-1:0] battery_ff, battery_in;
   logic [ByteWidth-1:0] status_ff, status_in;

   logic [ByteWidth-1:0] index_inc;
   logic [ByteWidth-1:0] check_sum;

   assign index_inc = index_ff + 8'd1;
   assign check_sum = length_ff + type_ff + address_ff + sum_ff;

   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      type_in      = type_ff;
      address_in   = address_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      yaw_in       = yaw_ff;
      battery_in   = battery_ff;
      status_in    = status_ff;
      result_valid = 1'b0;
      result.event_code    = EV_FRAME_OK;
      result.frame_type    = type_ff;
      result.frame_address = address_ff;
      result.frame_length  = length_ff;

      if (step_valid) begin
         unique case (phase_ff)
            PH_SYNC: begin
               if (step_byte == SyncByte) phase_in = PH_ZERO;
            end
            PH_ZERO: begin
               if (step_byte == ZeroByte) phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (step_byte < MinLength) begin
                  phase_in             = PH_SYNC;
                  index_in             = '0;
                  address_in           = '0;
                  length_in            = '0;
                  result_valid         = 1'b1;
                  result.event_code    = EV_BAD_LENGTH;
                  result.frame_type    = '0;
                  result.frame_address = '0;
                  result.frame_length  = step_byte;
               end else begin
                  length_in = step_byte;
                  phase_in  = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_in  = step_byte;
               phase_in = PH_ADDRESS;
            end
            PH_ADDRESS: begin
               address_in = step_byte;
               index_in   = '0;
               sum_in     = '0;
               first_in   = '0;
               second_in  = '0;
               phase_in   = PH_DATA;
            end
            PH_DATA: begin
               if (index_ff == 8'd0) first_in = step_byte;
               else if (index_ff == 8'd1) second_in = step_byte;
               sum_in   = sum_ff + step_byte;
               index_in = index_inc;
               // length is at least 9 here, so the subtract cannot wrap
               if (index_inc >= length_ff - FrameBytes) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (step_byte == ~check_sum) begin
                  phase_in = PH_TRAIL0;
               end else begin
                  phase_in          = PH_SYNC;
                  index_in          = '0;
                  address_in        = '0;
                  length_in         = '0;
                  result_valid      = 1'b1;
                  result.event_code = EV_CHECKSUM_ERR;
               end
            end
            PH_TRAIL0: begin
               if (step_byte == ZeroByte) begin
                  phase_in = PH_TRAIL1;
               end else begin
                  phase_in          = PH_SYNC;
                  index_in          = '0;
                  address_in        = '0;
                  length_in         = '0;
                  result_valid      = 1'b1;
                  result.event_code = EV_TRAILER_ERR;
               end
            end
            PH_TRAIL1: begin
               phase_in     = PH_SYNC;
               result_valid = 1'b1;
               if (step_byte == EndByte) begin
                  // yaw takes priority over battery, battery over status
                  if (address_ff == cfg.yaw_address) yaw_in = {first_ff, second_ff};
                  else if (address_ff == cfg.battery_address) battery_in = first_ff;
                  else if (address_ff == cfg.status_address) status_in = first_ff;
                  result.event_code = EV_FRAME_OK;
               end else begin
                  index_in          = '0;
                  address_in        = '0;
                  length_in         = '0;
                  result.event_code = EV_TRAILER_ERR;
               end
            end
            default: begin
               phase_in = PH_SYNC;
            end
         endcase
      end

      result.yaw_value         = yaw_in;
      result.battery_level     = battery_in;
      result.operational_state = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC;
         length_ff  <= '0;
         type_ff    <= '0;
         address_ff <= '0;
         index_ff   <= '0;
         sum_ff     <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         yaw_ff     <= '0;
         battery_ff <= '0;
         status_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         address_ff <= address_in;
         index_ff   <= index_in;
         sum_ff     <= sum_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         yaw_ff     <= yaw_in;
         battery_ff <= battery_in;
         status_ff  <= status_in;
      end
   end

endmodule

// ===== rtl/serial_frame_receiver_core.sv =====
`timescale 1ns / 1ps

// Serial frame receiver: parses 0x55 0x00 len type addr data.. csum 0x00 0xAA
// frames, one received byte per req_ word, and reports each finished,
// failed or rejected frame as one rsp_ word.
// Channels: req_ (valid/ready, one rx byte), rsp_ (valid/ready, event code,
// frame header bytes and the current yaw, battery and state stores) and
// csr_ (valid/ready write of the yaw, battery and status address registers).
// A byte accepted on req_ goes into the input register, is parsed from there,
// and its result word goes through the result register onto rsp_.
// Throughput: one byte per cycle while the result register is free or being
// drained; the parser step updates phase, data count and running 8-bit sum
// between the input register and the result register.
// Reset: parser goes back to hunting for 0x55, stores clear to zero, the
// address registers return to 0, 1 and 2, and both pipeline registers empty.
// Stall: while a result word waits unaccepted the parse step holds; the input
// register still takes one more byte, then req_ready drops. Bytes that make
// no result never wait on rsp_ready once the result register is free.
module serial_frame_receiver_core import sfr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // received byte stream
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_rx_byte,
   // frame events
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_event_code,
   output logic [ByteWidth-1:0]     rsp_frame_type,
   output logic [ByteWidth-1:0]     rsp_frame_address,
   output logic [ByteWidth-1:0]     rsp_frame_length,
   output logic signed [YawWidth-1:0] rsp_yaw_value,
   output logic [ByteWidth-1:0]     rsp_battery_level,
   output logic [ByteWidth-1:0]     rsp_operational_state,
   // address register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]     csr_data
);

   cfg_type              cfg_ff, cfg_in;

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;

   logic                 out_valid_ff, out_valid_in;
   result_type           out_data_ff;

   logic                 advance;
   logic                 step_valid;
   logic                 step_result_valid;
   result_type           step_result;

   // ---- configuration: always ready; to be written only while idle, which the block itself does not enforce
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_YAW_ADDR:     cfg_in.yaw_address     = csr_data;
            CSR_BATTERY_ADDR: cfg_in.battery_address = csr_data;
            CSR_STATUS_ADDR:  cfg_in.status_address  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_address     <= YawAddrReset;
         cfg_ff.battery_address <= BatteryAddrReset;
         cfg_ff.status_address  <= StatusAddrReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- pipeline control
   // The parse step fires when a byte sits in the input register and the
   // result register is free or being drained this cycle.
   assign advance    = !out_valid_ff || rsp_ready;
   assign step_valid = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? step_result_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_byte_ff <= req_rx_byte;
      if (advance && step_result_valid) out_data_ff <= step_result;
   end

   sfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step_valid),
      .step_byte    (in_byte_ff),
      .cfg          (cfg_ff),
      .result_valid (step_result_valid),
      .result       (step_result)
   );

   // ---- result word
   assign rsp_valid             = out_valid_ff;
   assign rsp_event_code        = out_data_ff.event_code;
   assign rsp_frame_type        = out_data_ff.frame_type;
   assign rsp_frame_address     = out_data_ff.frame_address;
   assign rsp_frame_length      = out_data_ff.frame_length;
   assign rsp_yaw_value         = signed'(out_data_ff.yaw_value);
   assign rsp_battery_level     = out_data_ff.battery_level;
   assign rsp_operational_state = out_data_ff.operational_state;

endmodule
